[design/dual_wheel_velocity_pid_macros.svh]
// Assertion helpers for the velocity controller
`ifndef DUAL_WHEEL_VELOCITY_PID_MACROS_SVH
`define DUAL_WHEEL_VELOCITY_PID_MACROS_SVH
`define DWV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DWV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[design/dwv_pkg.sv]
// ----------------------------------------------------------------------------
// dwv_pkg
// Shared types and constants for the dual wheel velocity controller.
// ----------------------------------------------------------------------------
package dwv_pkg;
  localparam int unsigned US_PER_S = 1000000;
  localparam int COUNT_WIDTH = 24;
  localparam int FRAC_BITS   = 16;

  typedef enum logic [1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1,
    REG_DERIV = 2'd2,
    REG_CPI   = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NEWC,
    ST_DIST_START,
    ST_DIST_WAIT,
    ST_VEL_MUL,
    ST_VEL_START,
    ST_VEL_WAIT,
    ST_ERR,
    ST_RATE_MUL,
    ST_RATE_START,
    ST_RATE_WAIT,
    ST_P_MUL,
    ST_I_MUL,
    ST_D_MUL,
    ST_DRIVE,
    ST_NEXT_WHEEL,
    ST_CLAMP,
    ST_OUT
  } state_t;
endpackage

[design/dwv_if.sv]
// ----------------------------------------------------------------------------
// dwv_if
// Valid/ready channel carrying a word of WIDTH bits.
// ----------------------------------------------------------------------------
interface dwv_if #(parameter int WIDTH = 8) (input logic clk);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/dual_wheel_velocity_pid.sv]
// ----------------------------------------------------------------------------
// dual_wheel_velocity_pid
// Velocity PID for a differential drive, bit-serial arithmetic.
// ----------------------------------------------------------------------------
// One word in, one word out. A control step runs both wheels in turn through
// one shared bit-serial divider (three divisions per wheel, for the distance,
// velocity and error rate) and one bit-serial multiplier (two scalings by 10^6
// and three gain products per wheel); the result word is valid once both
// wheels, the clamp and the output state are through. A reset word or a zero
// time step gives its result the cycle after it is accepted. The next word is
// taken once the result word has been taken and the block is idle.
module dual_wheel_velocity_pid (
  input  logic        clk,
  input  logic        rst,
  dwv_if.sink         in_ch,
  dwv_if.source       out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import dwv_pkg::*;
  `include "dual_wheel_velocity_pid_macros.svh"

  localparam logic signed [63:0] S32MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32MIN = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32MAX) return 32'h7fffffff;
    if (v < S32MIN) return 32'h80000000;
    return v[31:0];
  endfunction

  // configuration
  logic [23:0] prop_gain, integ_gain, deriv_gain, enc_per_in;
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= 24'd49152;
      integ_gain <= 24'd6554;
      deriv_gain <= 24'd7;
      enc_per_in <= 24'd2653488;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PROP:  prop_gain  <= cfg_data;
        REG_INTEG: integ_gain <= cfg_data;
        REG_DERIV: deriv_gain <= cfg_data;
        REG_CPI:   enc_per_in <= cfg_data;
        default:   ;
      endcase
    end
  end

  // input word: op, left, right, time, target (MSB first)
  logic                   w_op;
  logic [23:0]            w_left, w_right;
  logic [31:0]            w_now;
  logic signed [31:0]     w_tgt;
  assign w_tgt  = in_ch.data[31:0];
  assign w_now  = in_ch.data[63:32];
  assign w_right = in_ch.data[87:64];
  assign w_left = in_ch.data[111:88];
  assign w_op   = in_ch.data[112];

  // state
  logic signed [31:0] drive [2];
  logic signed [31:0] total [2];
  logic [COUNT_WIDTH-1:0] seen [2];
  logic signed [31:0] prior [2];
  logic signed [31:0] esum [2];
  logic [31:0]        prev_time;

  logic [COUNT_WIDTH-1:0] cnt_in [2];
  logic [31:0]        dt;
  logic signed [31:0] target;
  logic [31:0]        now_r;
  logic               wh;
  logic [63:0]        travel, tmp;
  logic signed [31:0] err, rate;
  logic signed [63:0] acc;
  logic               neg;
  logic               rate_neg;

  state_t state, state_next;

  // shared units
  logic        div_start, mul_start, div_done, mul_done;
  logic [63:0] div_num, div_den, div_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  dwv_divider #(.W(64)) u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .quo(div_q), .done(div_done)
  );
  dwv_multiplier #(.AW(32), .BW(32)) u_mul (
    .clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
    .prod(mul_p), .done(mul_done)
  );

  logic        out_valid;
  logic [96:0] out_data;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign in_ch.ready  = (state == ST_IDLE) && !out_valid;

  logic [COUNT_WIDTH-1:0] newc;
  logic [31:0]            mag_x;
  logic signed [31:0]     px;
  logic signed [63:0]     term;
  logic signed [63:0]     diff64;
  logic signed [63:0]     avg;
  logic [63:0]            vel;
  logic signed [31:0]     err_new;

  assign newc = cnt_in[wh] - seen[wh];
  assign avg  = ($signed({{32{total[0][31]}}, total[0]}) +
                 $signed({{32{total[1][31]}}, total[1]})) / 2;
  assign diff64 = 64'(err) - 64'(prior[wh]);
  assign vel = (div_q > 64'(S32MAX)) ? 64'(S32MAX) : div_q;
  assign err_new = sat32(64'(target) - $signed(vel));

  // operand selection for the multiplier
  always_comb begin
    px = err;
    unique case (state)
      ST_I_MUL: px = esum[wh];
      ST_D_MUL: px = rate;
      default:  px = err;
    endcase
    mag_x = px[31] ? 32'(-px) : px;
  end

  // term from a finished gain product
  assign term = neg ? -$signed({1'b0, 63'(mul_p >> FRAC_BITS)})
                    : $signed({1'b0, 63'(mul_p >> FRAC_BITS)});

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    div_num    = travel;
    div_den    = 64'(dt);
    mul_a      = 32'(US_PER_S);
    mul_b      = travel[31:0];
    unique case (state)
      ST_IDLE: if (in_ch.valid && in_ch.ready && !w_op && (w_now != prev_time))
        state_next = ST_NEWC;
      ST_NEWC: state_next = ST_DIST_START;
      ST_DIST_START: begin
        div_start = 1'b1;
        div_num = 64'(newc) << (2 * FRAC_BITS);
        div_den = 64'(enc_per_in);
        state_next = ST_DIST_WAIT;
      end
      ST_DIST_WAIT: if (div_done) state_next = ST_VEL_MUL;
      ST_VEL_MUL: begin
        mul_start = 1'b1;
        state_next = ST_VEL_START;
      end
      ST_VEL_START: if (mul_done) begin
        div_start = 1'b1;
        div_num = mul_p;
        state_next = ST_VEL_WAIT;
      end
      ST_VEL_WAIT: if (div_done) state_next = ST_ERR;
      ST_ERR: state_next = ST_RATE_MUL;
      ST_RATE_MUL: begin
        mul_start = 1'b1;
        mul_b = tmp[31:0];
        state_next = ST_RATE_START;
      end
      ST_RATE_START: if (mul_done) begin
        div_start = 1'b1;
        div_num = mul_p;
        state_next = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: if (div_done) state_next = ST_P_MUL;
      ST_P_MUL, ST_I_MUL, ST_D_MUL: begin
        mul_b = mag_x;
        mul_a = (state == ST_P_MUL) ? 32'(prop_gain) :
                (state == ST_I_MUL) ? 32'(integ_gain) : 32'(deriv_gain);
        if (!tmp[0]) mul_start = 1'b1;
        else if (mul_done)
          state_next = (state == ST_P_MUL) ? ST_I_MUL :
                       (state == ST_I_MUL) ? ST_D_MUL : ST_DRIVE;
      end
      ST_DRIVE: state_next = ST_NEXT_WHEEL;
      ST_NEXT_WHEEL: state_next = wh ? ST_CLAMP : ST_NEWC;
      ST_CLAMP: state_next = ST_OUT;
      ST_OUT: if (!out_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  logic [63:0] one_h;
  assign one_h = 64'(100) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        drive[i] <= '0; total[i] <= '0; seen[i] <= '0;
        prior[i] <= '0; esum[i]  <= '0;
      end
      prev_time <= '0;
      wh <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          cnt_in[0] <= COUNT_WIDTH'(w_left);
          cnt_in[1] <= COUNT_WIDTH'(w_right);
          target <= w_tgt;
          now_r  <= w_now;
          dt     <= w_now - prev_time;
          wh     <= 1'b0;
          if (w_op) begin
            for (int i = 0; i < 2; i++) begin
              drive[i] <= '0; total[i] <= '0; seen[i] <= '0;
              prior[i] <= '0; esum[i]  <= '0;
            end
            prev_time <= w_now;
            out_valid <= 1'b1;
            out_data  <= '0;
          end else if (w_now == prev_time) begin
            out_valid <= 1'b1;
            out_data  <= {drive[0], drive[1], sat32(avg), 1'b1};
          end
        end
        ST_DIST_WAIT: if (div_done) begin
          if (enc_per_in == '0 || div_q > 64'(S32MAX)) travel <= 64'(S32MAX);
          else travel <= div_q;
        end
        ST_VEL_WAIT: if (div_done) begin
          err <= err_new;
          esum[wh] <= sat32(64'(esum[wh]) + 64'(err_new));
        end
        ST_ERR: begin
          rate_neg <= diff64[63];
          tmp <= diff64[63] ? 64'(-diff64) : diff64;
        end
        ST_RATE_WAIT: begin
          if (div_done) begin
            rate <= rate_neg ? sat32(-$signed(div_q)) :
                    sat32((div_q > 64'(S32MAX)) ? S32MAX : $signed(div_q));
            acc <= 64'(drive[wh]);
            tmp <= '0;
          end
        end
        ST_P_MUL, ST_I_MUL, ST_D_MUL: begin
          if (!tmp[0]) begin
            tmp[0] <= 1'b1;
            neg <= px[31];
          end else if (mul_done) begin
            acc <= acc + 64'(sat32(term));
            tmp[0] <= 1'b0;
          end
        end
        ST_DRIVE: begin
          drive[wh] <= sat32(acc);
          prior[wh] <= err;
          seen[wh]  <= cnt_in[wh];
          total[wh] <= sat32(64'(total[wh]) + $signed(travel));
        end
        ST_NEXT_WHEEL: wh <= ~wh;
        ST_CLAMP: begin
          prev_time <= now_r;
          if (64'(drive[0]) > $signed(one_h - (64'(1) << FRAC_BITS)) ||
              64'(drive[1]) > $signed(one_h - (64'(1) << FRAC_BITS))) begin
            drive[0] <= sat32($signed(one_h));
            drive[1] <= sat32($signed(one_h));
          end
        end
        ST_OUT: if (!out_valid) begin
          out_valid <= 1'b1;
          out_data  <= {drive[0], drive[1], sat32(avg), 1'b0};
        end
        default: ;
      endcase
    end
  end

  `DWV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ch.ready, out_valid)
  `DWV_ASSERT_NEXT(a_no_take_busy, clk, rst, state != ST_IDLE, !in_ch.ready)
  `DWV_ASSERT_NEXT(a_div_one, clk, rst, div_start, !div_done)
endmodule

[design/dwv_divider.sv]
// ----------------------------------------------------------------------------
// dwv_divider
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module dwv_divider #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] quo,
  output logic         done
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [W-1:0]  d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;

  assign trial = {rem, q[W-1]} - {1'b0, d};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        q    <= num;
        d    <= den;
        rem  <= '0;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          q   <= {q[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], q[W-1]};
          q   <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[design/dwv_multiplier.sv]
// ----------------------------------------------------------------------------
// dwv_multiplier
// Shift-add multiplier, one multiplier bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module dwv_multiplier #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] prod,
  output logic            done
);
  localparam int CW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc;
  logic [AW+BW-1:0] sh;
  logic [BW-1:0]    bb;
  logic [CW-1:0]    cnt;
  logic             busy;

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc  <= '0;
        sh   <= (AW+BW)'(a);
        bb   <= b;
        cnt  <= CW'(BW);
      end else if (busy) begin
        if (bb[0]) acc <= acc + sh;
        sh  <= {sh[AW+BW-2:0], 1'b0};
        bb  <= bb >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dual_wheel_velocity_pid: random and directed
// step/reset words, a local fixed-point copy of the controller predicts
// every result word, the checker compares them in order.
// ----------------------------------------------------------------------------
module tb;
  import dwv_pkg::*;

  localparam int IN_W  = 113;
  localparam int OUT_W = 97;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef enum logic {OP_STEP = 1'b0, OP_RESET = 1'b1} op_t;

  typedef struct packed {
    op_t                op;
    logic [23:0]        left_count;
    logic [23:0]        right_count;
    logic [31:0]        time_now_us;
    logic signed [31:0] target_speed;
  } step_word_t;

  typedef struct packed {
    logic signed [31:0] left_power;
    logic signed [31:0] right_power;
    logic signed [31:0] distance_avg;
    logic               zero_interval;
  } power_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  dwv_if #(.WIDTH(IN_W))  in_ch (.clk(clk));
  dwv_if #(.WIDTH(OUT_W)) out_ch (.clk(clk));

  dual_wheel_velocity_pid dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // controller copy
  logic [23:0]        kp, ki, kd, cpi;
  logic signed [31:0] drive [2];
  logic signed [31:0] total [2];
  logic signed [31:0] prior [2];
  logic signed [31:0] esum [2];
  logic [23:0]        seen [2];
  logic [31:0]        prev_time;

  power_word_t expected_powers [$];
  int   fail_count = 0;
  longint cycles = 0;
  bit   quiet = 1'b0;
  int   gap_prob = 30;

  // stimulus trackers
  logic [31:0] cur_time;
  logic [23:0] cur_l, cur_r;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > S32_MAX) return S32_MAX[31:0];
    if (v < S32_MIN) return S32_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] gain_term(logic [23:0] g, longint x);
    longint gl, p, m;
    gl = g;
    p = gl * x;
    m = (p < 0) ? -p : p;
    m = m >> 16;
    return sat32((p < 0) ? -m : m);
  endfunction

  function automatic void clear_ctrl();
    for (int w = 0; w < 2; w++) begin
      drive[w] = 0; total[w] = 0; prior[w] = 0; esum[w] = 0; seen[w] = 0;
    end
    prev_time = 0;
  endfunction

  function automatic void run_wheel(int w, logic [23:0] cnt, logic [31:0] dt,
                                    logic signed [31:0] tgt);
    logic [23:0] n;
    logic [63:0] q;
    longint travel, vel, dtl, err, rate, acc, t;
    n = cnt - seen[w];
    if (cpi == 0) travel = S32_MAX;
    else begin
      q = {40'b0, n} << 32;
      q = q / {40'b0, cpi};
      travel = (q > 64'(S32_MAX)) ? S32_MAX : longint'(q);
    end
    dtl = dt;
    vel = (travel * 1000000) / dtl;
    if (vel > S32_MAX) vel = S32_MAX;
    t = tgt;
    err = sat32(t - vel);
    esum[w] = sat32(longint'(esum[w]) + err);
    rate = sat32(((err - longint'(prior[w])) * 1000000) / dtl);
    acc = longint'(drive[w]) + gain_term(kp, err) + gain_term(ki, esum[w])
        + gain_term(kd, rate);
    drive[w] = sat32(acc);
    prior[w] = err[31:0];
    seen[w] = cnt;
    total[w] = sat32(longint'(total[w]) + travel);
  endfunction

  function automatic power_word_t predict_powers(step_word_t s);
    power_word_t r;
    logic [31:0] dt;
    r.zero_interval = 1'b0;
    if (s.op == OP_RESET) begin
      clear_ctrl();
      prev_time = s.time_now_us;
    end else begin
      dt = s.time_now_us - prev_time;
      if (dt == 0) r.zero_interval = 1'b1;
      else begin
        run_wheel(0, s.left_count, dt, s.target_speed);
        run_wheel(1, s.right_count, dt, s.target_speed);
        prev_time = s.time_now_us;
        if (longint'(drive[0]) > 99 * 65536 || longint'(drive[1]) > 99 * 65536) begin
          drive[0] = 100 * 65536;
          drive[1] = 100 * 65536;
        end
      end
    end
    r.left_power = drive[0];
    r.right_power = drive[1];
    r.distance_avg = sat32((longint'(total[0]) + longint'(total[1])) / 2);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    power_word_t got, exp_w;
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_powers.size() == 0) begin
        $error("unexpected word %h", got);
        fail_count++;
      end else begin
        exp_w = expected_powers.pop_front();
        if (got.left_power !== exp_w.left_power) begin
          $error("left_power exp %h got %h", exp_w.left_power, got.left_power);
          fail_count++;
        end
        if (got.right_power !== exp_w.right_power) begin
          $error("right_power exp %h got %h", exp_w.right_power, got.right_power);
          fail_count++;
        end
        if (got.distance_avg !== exp_w.distance_avg) begin
          $error("distance_avg exp %h got %h", exp_w.distance_avg, got.distance_avg);
          fail_count++;
        end
        if (got.zero_interval !== exp_w.zero_interval) begin
          $error("zero_interval exp %b got %b", exp_w.zero_interval, got.zero_interval);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls in bursts, except in quiet mode
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || quiet) out_ch.ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(99) < 25) begin
      stall_left <= $urandom_range(9);
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send_word(step_word_t s);
    if (!quiet && $urandom_range(99) < gap_prob) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_powers.push_back(predict_powers(s));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PROP:  kp = v;
      REG_INTEG: ki = v;
      REG_DERIV: kd = v;
      REG_CPI:   cpi = v;
    endcase
  endtask

  function automatic step_word_t mk(op_t op, logic [23:0] l, logic [23:0] r,
                                    logic [31:0] t, logic [31:0] tgt);
    step_word_t s;
    s.op = op; s.left_count = l; s.right_count = r;
    s.time_now_us = t; s.target_speed = tgt;
    return s;
  endfunction

  task automatic test_directed();
    send_word(mk(OP_STEP, 24'd100, 24'd50, 32'd50000, 32'h000c_0000));
    send_word(mk(OP_STEP, 24'd100, 24'd50, 32'd50000, 32'h000c_0000)); // zero dt
    send_word(mk(OP_RESET, 24'hffffff, 24'hffffff, 32'hffff_ff00, 32'h7fff_ffff));
    send_word(mk(OP_STEP, 24'd400, 24'd380, 32'h0000_0100, 32'h000a_0000)); // wrap
    send_word(mk(OP_STEP, 24'hffffff, 24'h0, 32'h0000_0101, 32'h8000_0000));
    send_word(mk(OP_STEP, 24'h0, 24'hffffff, 32'hffff_ffff, 32'h7fff_ffff));
    send_word(mk(OP_STEP, 24'h0, 24'h0, 32'h0, 32'h0));
    send_word(mk(OP_STEP, 24'h123, 24'h456, 32'h0, 32'hffff_ffff)); // zero dt
    send_word(mk(OP_STEP, 24'h800000, 24'h7fffff, 32'h8000_0000, 32'h0064_0000));
    send_word(mk(OP_RESET, 24'h0, 24'h0, 32'h0, 32'h0));
    for (int i = 1; i <= 6; i++)
      send_word(mk(OP_STEP, 24'(i * 2000), 24'(i * 1900), 32'(i * 50000),
                   32'h0064_0000));
    drain();
    set_reg(REG_CPI, 24'd65536);
    set_reg(REG_PROP, 24'hffffff);
    set_reg(REG_INTEG, 24'hffffff);
    set_reg(REG_DERIV, 24'hffffff);
    send_word(mk(OP_STEP, 24'hffffff, 24'h10, 32'h0040_0000, 32'h8000_0000));
    send_word(mk(OP_STEP, 24'h10, 24'hffffff, 32'h0040_0001, 32'h7fff_ffff));
    drain();
    set_reg(REG_CPI, 24'd0); // distance pins at max
    set_reg(REG_PROP, 24'd0);
    set_reg(REG_INTEG, 24'd0);
    set_reg(REG_DERIV, 24'd0);
    send_word(mk(OP_STEP, 24'h55, 24'haa, 32'h0050_0000, 32'h0001_0000));
    send_word(mk(OP_STEP, 24'h56, 24'hab, 32'h0050_c350, 32'h0001_0000));
    drain();
  endtask

  task automatic send_random(int n);
    step_word_t s;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 4) begin
        cur_time = $urandom;
        s = mk(OP_RESET, 24'($urandom), 24'($urandom), cur_time, $urandom);
        cur_l = 0; cur_r = 0;
      end else begin
        sel = $urandom_range(99);
        if (sel < 5) cur_time = cur_time;
        else if (sel < 10) cur_time = cur_time + 1;
        else if (sel < 15) cur_time = $urandom;
        else cur_time = cur_time + $urandom_range(100000, 20000);
        if ($urandom_range(99) < 8) begin
          cur_l = 24'($urandom); cur_r = 24'($urandom);
        end else begin
          cur_l = cur_l + 24'($urandom_range(3000));
          cur_r = cur_r + 24'($urandom_range(3000));
        end
        s = mk(OP_STEP, cur_l, cur_r, cur_time,
               ($urandom_range(99) < 15) ? $urandom
                 : 32'(($urandom_range(120) - 60) * 65536 + $urandom_range(65535)));
      end
      send_word(s);
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 3) begin
        set_reg(REG_PROP, 24'($urandom_range(98304)));
        set_reg(REG_INTEG, 24'($urandom_range(13107)));
        set_reg(REG_DERIV, 24'($urandom_range(100)));
        set_reg(REG_CPI, 24'($urandom_range(6000000, 65536)));
      end else begin
        set_reg(REG_PROP, 24'($urandom));
        set_reg(REG_INTEG, 24'($urandom));
        set_reg(REG_DERIV, 24'($urandom));
        set_reg(REG_CPI, 24'($urandom_range(24'hffffff, 65536)));
      end
      send_word(mk(OP_RESET, 24'h0, 24'h0, cur_time, 32'h0));
      cur_l = 0; cur_r = 0;
      send_random(200);
      drain();
    end
  endtask

  task automatic test_streaming();
    quiet = 1'b1;
    set_reg(REG_PROP, 24'd49152);
    set_reg(REG_INTEG, 24'd6554);
    set_reg(REG_DERIV, 24'd7);
    set_reg(REG_CPI, 24'd2653488);
    send_random(250);
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    kp = 24'd49152; ki = 24'd6554; kd = 24'd7; cpi = 24'd2653488;
    clear_ctrl();
    cur_time = 0; cur_l = 0; cur_r = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_streaming();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/dwv_pkg.sv
design/dwv_if.sv
design/dwv_divider.sv
design/dwv_multiplier.sv
design/dual_wheel_velocity_pid.sv
test/tb.sv
